/* rtl/core/scrp_pkg.sv */
// shared types, constants and helpers for the serial read command parser
`default_nettype none

package scrp_pkg;

  // number of hex digits in each number of a read command
  localparam int unsigned HEX_DIGITS = 8;
  // digit counter holds 0 .. HEX_DIGITS
  localparam int unsigned CNT_W = $clog2(HEX_DIGITS + 1);

  localparam int unsigned NUM_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;

  // result payload width, packed and padded to whole bytes
  localparam int unsigned RES_W  = KIND_W + NUM_W + NUM_W + BYTE_W;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_UC_R  = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_LC_R  = 8'h72;
  localparam logic [BYTE_W-1:0] CHAR_UC_H  = 8'h48;
  localparam logic [BYTE_W-1:0] CHAR_LC_H  = 8'h68;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LC_F  = 8'h66;

  // line result codes
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 3'd0,
    KIND_HELP  = 3'd1,
    KIND_READ  = 3'd2,
    KIND_UNEXP = 3'd3,
    KIND_LONG  = 3'd4
  } kind_t;

  // parse phases, one-hot
  typedef enum logic [7:0] {
    PH_START    = 8'b0000_0001,
    PH_ADDR_SP  = 8'b0000_0010,
    PH_ADDR_DIG = 8'b0000_0100,
    PH_ADDR_END = 8'b0000_1000,
    PH_LEN_SP   = 8'b0001_0000,
    PH_LEN_DIG  = 8'b0010_0000,
    PH_LEN_END  = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t             phase;
    logic [NUM_W-1:0]   addr;
    logic [NUM_W-1:0]   len;
    logic [CNT_W-1:0]   cnt;
    kind_t              kind;
    logic [BYTE_W-1:0]  bad;
  } parse_state_t;

  // one finished line
  typedef struct packed {
    logic [BYTE_W-1:0]  offending_byte;
    logic [NUM_W-1:0]   read_length;
    logic [NUM_W-1:0]   start_address;
    kind_t              line_kind;
  } line_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_START,
    addr:  '0,
    len:   '0,
    cnt:   '0,
    kind:  KIND_NONE,
    bad:   '0
  };

  // hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      r = {1'b1, 4'(b - CHAR_0)};
    end else if (b >= CHAR_LC_A && b <= CHAR_LC_F) begin
      r = {1'b1, 4'(b - CHAR_LC_A + 8'd10)};
    end else if (b >= CHAR_UC_A && b <= CHAR_UC_F) begin
      r = {1'b1, 4'(b - CHAR_UC_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scrp_step.sv */
// next-state and line result logic for one received byte
`default_nettype none

module scrp_step (
  input  scrp_pkg::parse_state_t        cur,
  input  logic [scrp_pkg::BYTE_W-1:0]   rx_byte,
  output scrp_pkg::parse_state_t        nxt,
  output logic                          line_end,
  output scrp_pkg::line_result_t        res
);
  import scrp_pkg::*;

  logic [BYTE_W-1:0] b;
  logic [4:0]        hex;
  logic [CNT_W-1:0]  cnt_inc;
  logic              in_addr;
  logic [NUM_W-1:0]  acc_sel;
  logic [NUM_W-1:0]  acc_upd;
  parse_state_t      fed;

  // a line end is fed to the parser as a zero byte
  assign line_end = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign b        = line_end ? CHAR_NUL : rx_byte;

  // shared digit path for both numbers
  assign hex     = hex_decode(b);
  assign in_addr = (cur.phase == PH_ADDR_SP) || (cur.phase == PH_ADDR_DIG);
  assign acc_sel = in_addr ? cur.addr : cur.len;
  assign acc_upd = {acc_sel[NUM_W-5:0], hex[3:0]};
  assign cnt_inc = cur.cnt + CNT_W'(1);

  // parse one byte
  always_comb begin
    fed = cur;
    case (cur.phase)
      PH_START: begin
        if (b == CHAR_UC_R || b == CHAR_LC_R) begin
          fed.phase = PH_ADDR_SP;
        end else if (b == CHAR_UC_H || b == CHAR_LC_H) begin
          fed.kind  = KIND_HELP;
          fed.bad   = '0;
          fed.phase = PH_DONE;
        end else begin
          fed.kind  = KIND_NONE;
          fed.bad   = '0;
          fed.phase = PH_DONE;
        end
      end
      PH_ADDR_SP, PH_ADDR_DIG, PH_LEN_SP, PH_LEN_DIG: begin
        if ((cur.phase == PH_ADDR_SP || cur.phase == PH_LEN_SP) && b == CHAR_SPACE) begin
          fed = cur;
        end else if (!hex[4]) begin
          fed.kind  = KIND_UNEXP;
          fed.bad   = b;
          fed.phase = PH_DONE;
        end else begin
          if (in_addr) begin
            fed.addr = acc_upd;
          end else begin
            fed.len = acc_upd;
          end
          if (cnt_inc >= CNT_W'(HEX_DIGITS)) begin
            fed.cnt   = '0;
            fed.phase = in_addr ? PH_ADDR_END : PH_LEN_END;
          end else begin
            fed.cnt   = cnt_inc;
            fed.phase = in_addr ? PH_ADDR_DIG : PH_LEN_DIG;
          end
        end
      end
      PH_ADDR_END: begin
        if (b == CHAR_SPACE) begin
          fed.phase = PH_LEN_SP;
        end else if (b == CHAR_NUL) begin
          fed.kind  = KIND_UNEXP;
          fed.bad   = '0;
          fed.phase = PH_DONE;
        end else begin
          fed.kind  = KIND_LONG;
          fed.bad   = b;
          fed.phase = PH_DONE;
        end
      end
      PH_LEN_END: begin
        if (b == CHAR_SPACE || b == CHAR_NUL) begin
          fed.kind  = KIND_READ;
          fed.bad   = '0;
          fed.phase = PH_DONE;
        end else begin
          fed.kind  = KIND_LONG;
          fed.bad   = b;
          fed.phase = PH_DONE;
        end
      end
      default: begin
        fed = cur;
      end
    endcase
  end

  // result of the line and state for the next byte
  always_comb begin
    res.line_kind      = fed.kind;
    res.start_address  = (fed.kind == KIND_READ) ? fed.addr : '0;
    res.read_length    = (fed.kind == KIND_READ) ? fed.len : '0;
    res.offending_byte = fed.bad;
    nxt = line_end ? STATE_RESET : fed;
  end

endmodule

`default_nettype wire

/* rtl/core/serial_read_command_parser.sv */
// top level of the serial read command parser
`default_nettype none

// Parses monitor command lines from a byte stream. Each byte on s_tdata is one
// received character; a carriage return or line feed ends the line and gives
// exactly one result on m_tdata, other bytes give none. A line starting with
// H/h is help; R/r is a read with two eight-digit hex numbers (address, then
// byte count); anything else is none; malformed reads give an error kind with
// the offending byte. Each byte is registered on entry and parsed into the
// parser state and, at a line end, into the result register, so one byte per
// cycle is sustained unless a line end stalls; a line end passes through the
// input register, then the result register. A line end waits in the input
// register only while the result register is full and not being taken.

module serial_read_command_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] line_kind, [34:3] start_address, [66:35] read_length,
  // [74:67] offending_byte, [79:75] zero
  output logic [scrp_pkg::TDATA_W-1:0]      m_tdata
);
  import scrp_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  parse_state_t      state;
  parse_state_t      state_next;
  logic              line_end;
  line_result_t      res;
  line_result_t      out_res;
  logic              out_free;
  logic              step_go;

  // the byte in the input register moves on unless it is a line end facing a full output
  assign out_free = !m_tvalid || m_tready;
  assign step_go  = in_valid && (!line_end || out_free);
  assign s_tready = !in_valid || step_go;

  scrp_step u_step (
    .cur      (state),
    .rx_byte  (in_byte),
    .nxt      (state_next),
    .line_end (line_end),
    .res      (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (step_go) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_go && line_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (step_go && line_end) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(TDATA_W - RES_W)'(0), out_res};

endmodule

`default_nettype wire

/* rtl/core/scrp_checker.sv */
// port-level checks for the serial read command parser
`default_nettype none

module scrp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [scrp_pkg::TDATA_W-1:0]  m_tdata
);
  import scrp_pkg::*;

  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] off;

  assign kind    = m_tdata[KIND_W-1:0];
  assign off     = m_tdata[RES_W-1 -: BYTE_W];

  // only defined line kinds appear
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (kind == KIND_NONE || kind == KIND_HELP || kind == KIND_READ ||
                  kind == KIND_UNEXP || kind == KIND_LONG))
    else $error("undefined line kind");

  // numbers are zero unless the line is a read
  a_numbers_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind != KIND_READ) |-> (m_tdata[KIND_W+2*NUM_W-1:KIND_W] == '0))
    else $error("numbers set on a non-read line");

  // no offending byte without an error
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (kind == KIND_NONE || kind == KIND_HELP || kind == KIND_READ))
      |-> (off == '0))
    else $error("offending byte set without an error");

  // a too-long number is always blamed on a real, non-space byte
  a_long_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind == KIND_LONG) |-> (off != CHAR_NUL && off != CHAR_SPACE))
    else $error("too-long error with a space or zero byte");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind serial_read_command_parser scrp_checker u_scrp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
